### rtl/core/zero_cross_phase_meter_top_defines.svh
// Assertion macros for the zero-cross phase meter checker.
`ifndef ZERO_CROSS_PHASE_METER_TOP_DEFINES_SVH
`define ZERO_CROSS_PHASE_METER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ZCPM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("zcpm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ZCPM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("zcpm: next-cycle check failed");

`endif

### rtl/core/zcpm_pkg.sv
// Package: widths, constants and transaction types of the zero-cross phase meter.
`timescale 1ns / 1ps
package zcpm_pkg;

   localparam int COUNT_BITS  = 32;
   localparam int PERIOD_BITS = 24;
   localparam int PHASE_BITS  = 10;
   localparam int LEAD_BITS   = 32;
   localparam int TURN        = 360;
   localparam int TURN_BITS   = 9;
   localparam int PROD_BITS   = COUNT_BITS + TURN_BITS;
   localparam int STEP_BITS   = $clog2(PROD_BITS);
   localparam int QUOT_BITS   = PHASE_BITS;
   // 360 has four set bits: column sum <= 4 + carry, so carry stays below 4
   localparam int CARRY_BITS  = 2;

   localparam logic [TURN_BITS-1:0]   TURN_VEC     = TURN_BITS'(TURN);
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(100000);

   typedef struct packed {
      logic ref_level;
      logic test_level;
   } req_type;

   typedef struct packed {
      logic signed [PHASE_BITS-1:0] phase_degrees;
      logic                         ref_leads;
      logic [LEAD_BITS-1:0]         lead_ticks;
   } rsp_type;

   // tracker -> top: one measurement finished on this transaction
   typedef struct packed {
      logic                  fire;
      logic                  leader_ref;
      logic [COUNT_BITS-1:0] count;
   } track_evt_type;

   function automatic logic [LEAD_BITS-1:0] lead_sat(input logic [COUNT_BITS-1:0] cnt);
      logic [LEAD_BITS-1:0] res;
      if (64'(cnt) > 64'({LEAD_BITS{1'b1}}))
         res = {LEAD_BITS{1'b1}};
      else
         res = LEAD_BITS'(cnt);
      return res;
   endfunction

endpackage

### rtl/core/zcpm_track.sv
// Edge tracker: arms on both-low, picks the leader, counts ticks to the lagger.
`timescale 1ns / 1ps
module zcpm_track
   import zcpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  req_type       levels,
   output track_evt_type evt
);

   typedef enum logic [1:0] {
      MODE_WAIT_LOW  = 2'd0,
      MODE_WAIT_RISE = 2'd1,
      MODE_COUNT     = 2'd2
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic                  leader_ff, leader_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  fire;

   always_comb begin
      mode_in   = mode_ff;
      leader_in = leader_ff;
      count_in  = count_ff;
      fire      = 1'b0;
      if (accept) begin
         case (mode_ff)
            MODE_WAIT_RISE: begin
               if (levels.ref_level || levels.test_level) begin
                  // simultaneous rise: test leads
                  leader_in = !levels.test_level;
                  count_in  = '0;
                  mode_in   = MODE_COUNT;
                  fire      = leader_in ? levels.test_level : levels.ref_level;
               end
            end
            MODE_COUNT: begin
               count_in = (&count_ff) ? count_ff : count_ff + 1'b1;
               fire     = leader_ff ? levels.test_level : levels.ref_level;
            end
            default: begin
               mode_in = (!levels.ref_level && !levels.test_level) ?
                         MODE_WAIT_RISE : MODE_WAIT_LOW;
            end
         endcase
         if (fire)
            mode_in = MODE_WAIT_LOW;
      end
   end

   assign evt.fire       = fire;
   assign evt.leader_ref = leader_in;
   assign evt.count      = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_WAIT_LOW;
         leader_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         leader_ff <= leader_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/zcpm_mul.sv
// Bit-serial constant multiplier: count * 360, product bits LSB first.
`timescale 1ns / 1ps
module zcpm_mul
   import zcpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] operand,
   output logic                  done,
   output logic [PROD_BITS-1:0]  product
);

   logic [COUNT_BITS-1:0] opnd_ff, opnd_in;
   logic [TURN_BITS-2:0]  hist_ff, hist_in;    // hist[i] = operand bit k-1-i
   logic [CARRY_BITS-1:0] carry_ff, carry_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [TURN_BITS-1:0]  taps;
   logic [CARRY_BITS:0]   col_sum;

   always_comb begin
      taps    = {hist_ff, opnd_ff[0]};
      col_sum = {1'b0, carry_ff};
      for (int i = 0; i < TURN_BITS; i++)
         col_sum = col_sum + (CARRY_BITS+1)'(taps[i] & TURN_VEC[i]);
   end

   always_comb begin
      opnd_in  = opnd_ff;
      hist_in  = hist_ff;
      carry_in = carry_ff;
      prod_in  = prod_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         opnd_in  = operand;
         hist_in  = '0;
         carry_in = '0;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         opnd_in  = opnd_ff >> 1;
         hist_in  = {hist_ff[TURN_BITS-3:0], opnd_ff[0]};
         carry_in = col_sum[CARRY_BITS:1];
         prod_in  = {col_sum[0], prod_ff[PROD_BITS-1:1]};
         step_in  = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(PROD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff  <= opnd_in;
      hist_ff  <= hist_in;
      carry_ff <= carry_in;
      prod_ff  <= prod_in;
      step_ff  <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

### rtl/core/zcpm_div.sv
// Bit-serial restoring divider: product / period, quotient clamped at 360.
`timescale 1ns / 1ps
module zcpm_div
   import zcpm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [PROD_BITS-1:0]   dividend,
   input  logic [PERIOD_BITS-1:0] divisor,
   output logic                   done,
   output logic [TURN_BITS-1:0]   magnitude
);

   logic [PROD_BITS-1:0]   dvd_ff, dvd_in;
   logic [PERIOD_BITS-1:0] rem_ff, rem_in;
   logic [QUOT_BITS-1:0]   quo_ff, quo_in;
   logic                   ovf_ff, ovf_in;    // a quotient bit fell off the top
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [PERIOD_BITS-1:0] dsr;
   logic [PERIOD_BITS:0]   trial;
   logic                   fits;

   // zero period acts as one
   assign dsr   = (divisor == '0) ? PERIOD_BITS'(1) : divisor;
   assign trial = {rem_ff, dvd_ff[PROD_BITS-1]};
   assign fits  = trial >= {1'b0, dsr};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in  = dvd_ff << 1;
         rem_in  = fits ? PERIOD_BITS'(trial - {1'b0, dsr}) : PERIOD_BITS'(trial);
         quo_in  = {quo_ff[QUOT_BITS-2:0], fits};
         ovf_in  = ovf_ff | quo_ff[QUOT_BITS-1];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(PROD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      ovf_ff  <= ovf_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign magnitude = (ovf_ff || quo_ff > QUOT_BITS'(TURN)) ? TURN_VEC
                                                            : quo_ff[TURN_BITS-1:0];

endmodule

### rtl/core/zero_cross_phase_meter_top.sv
// Throughput: one transaction per cycle while no measurement completes; after one
//   completes, no transaction is taken until its result has been through two
//   bit-serial passes (multiply by 360, then divide by the period) and has been
//   loaded into the output register.
// Reset: synchronous, active high; rearms the tracker, period back to 100000 ticks,
//   result register empty.
`timescale 1ns / 1ps
module zero_cross_phase_meter_top
   import zcpm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // tick transactions
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // phase results
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // period register
   input  logic                   csr_we,
   input  logic [PERIOD_BITS-1:0] csr_wdata
);

   // IDLE takes ticks; MUL and DIV run the serial units; HOLD parks a finished
   // result while the output register is still occupied.
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DIV  = 2'd2,
      ST_HOLD = 2'd3
   } state_type;

   state_type              state_ff, state_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic                   leader_ff, leader_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   track_evt_type          evt;
   logic                   mul_done;
   logic [PROD_BITS-1:0]   product;
   logic                   div_done;
   logic [TURN_BITS-1:0]   magnitude;
   logic                   slot_free;
   logic                   load_rsp;
   logic [PHASE_BITS-1:0]  mag_ext;

   // one tick at a time through the tracker; stalled while a measurement is computed or its result is held
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   zcpm_track u_track (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .levels (req_data),
      .evt    (evt)
   );

   zcpm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (evt.fire),
      .operand (evt.count),
      .done    (mul_done),
      .product (product)
   );

   zcpm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_done),
      .dividend  (product),
      .divisor   (period_ff),
      .done      (div_done),
      .magnitude (magnitude)
   );

   // output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = ((state_ff == ST_DIV && div_done) || state_ff == ST_HOLD) && slot_free;
   assign mag_ext   = PHASE_BITS'(magnitude);

   always_comb begin
      state_in  = state_ff;
      period_in = csr_we ? csr_wdata : period_ff;
      leader_in = leader_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (evt.fire) begin
               leader_in = evt.leader_ref;
               cnt_in    = evt.count;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done)
               state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done)
               state_in = slot_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            if (slot_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in              = 1'b1;
         // negative phase when the reference leads
         rsp_data_in.phase_degrees = leader_ff ? -mag_ext : mag_ext;
         rsp_data_in.ref_leads     = leader_ff;
         rsp_data_in.lead_ticks    = lead_sat(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      leader_ff   <= leader_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/zcpm_checker.sv
// Port-level checker for the zero-cross phase meter, bound to the top level.
`timescale 1ns / 1ps
`include "zero_cross_phase_meter_top_defines.svh"
module zcpm_checker
   import zcpm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic signed [PHASE_BITS-1:0] phase;

   assign phase = rsp_data.phase_degrees;

   `ZCPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `ZCPM_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data))
   `ZCPM_ASSERT_NOW(a_phase_range, rsp_valid, (phase >= -10'sd360) && (phase <= 10'sd360))
   `ZCPM_ASSERT_NOW(a_phase_sign, rsp_valid && !rsp_data.ref_leads, !phase[PHASE_BITS-1])
   `ZCPM_ASSERT_NOW(a_zero_lead, rsp_valid && (rsp_data.lead_ticks == '0), phase == '0)

endmodule

bind zero_cross_phase_meter_top zcpm_checker u_zcpm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
